[src/mlfq_task_scheduler_top_defines.svh]
// Assertion macros for the feedback queue scheduler checks
`ifndef MLFQ_TASK_SCHEDULER_TOP_DEFINES_SVH
`define MLFQ_TASK_SCHEDULER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define MLFQ_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mlfq scheduler check failed");

// next-cycle implication, sampled on clock, off during reset
`define MLFQ_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mlfq scheduler check failed");

`endif

[src/mlfq_pkg.sv]
// Types, constants and codes shared by the feedback queue scheduler
package mlfq_pkg;

   localparam int NUM_TASKS  = 64;
   localparam int NUM_LEVELS = 4;
   localparam int NUM_SLICES = 4;
   localparam int TASK_W     = $clog2(NUM_TASKS);
   localparam int LEVEL_W    = $clog2(NUM_LEVELS);
   localparam int TICK_W     = 16;
   localparam int BOOST_W    = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [2:0] KIND_TICK     = 3'd0;
   localparam logic [2:0] KIND_CREATE   = 3'd1;
   localparam logic [2:0] KIND_WAKE     = 3'd2;
   localparam logic [2:0] KIND_YIELD    = 3'd3;
   localparam logic [2:0] KIND_BLOCK    = 3'd4;
   localparam logic [2:0] KIND_DISPATCH = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_SLICE0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLICE1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLICE2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SLICE3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BOOST  = 3'd4;

   localparam logic [TICK_W-1:0] SLICE_RESET [NUM_SLICES] = '{16'd5, 16'd10, 16'd20, 16'd40};
   localparam logic [BOOST_W-1:0] BOOST_RESET = 32'd100;

   typedef enum logic [1:0] {
      ST_UNUSED  = 2'd0,
      ST_BLOCKED = 2'd1,
      ST_READY   = 2'd2,
      ST_RUNNING = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [5:0] task_req;
   } req_type;

   typedef struct packed {
      logic       dispatched;
      logic [5:0] granted_task;
      logic [1:0] granted_level;
      logic       boosted;
      logic       demoted;
   } rsp_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [TICK_W-1:0]  ticks;
      status_type         status;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_EXEC,
      S_UL_CHECK,
      S_UL_NEXT,
      S_B_READ,
      S_B_EXEC,
      S_RESP
   } state_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_READ,
      CMD_EXEC,
      CMD_UL_CHECK,
      CMD_UL_NEXT,
      CMD_B_READ,
      CMD_B_EXEC
   } cmd_type;

   typedef struct packed {
      logic need_unlink;
      logic need_boost;
      logic ul_more;
      logic ul_match;
      logic boost_last;
   } stat_type;

endpackage

[src/mlfq_ram.sv]
// Generic single write, single registered read RAM
module mlfq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/mlfq_ctrl.sv]
// Sequencer for the scheduler: steps each event through read, execute, walks and response
module mlfq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  mlfq_pkg::stat_type stat,
   output mlfq_pkg::cmd_type  cmd,
   output logic              busy,
   output logic              rsp_strobe
);
   import mlfq_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (start) state_in = S_READ;
         S_READ:     state_in = S_EXEC;
         S_EXEC: begin
            priority if (stat.need_unlink) state_in = S_UL_CHECK;
            else if (stat.need_boost)      state_in = S_B_READ;
            else                           state_in = S_RESP;
         end
         S_UL_CHECK: state_in = stat.ul_more ? S_UL_NEXT : S_RESP;
         S_UL_NEXT:  state_in = stat.ul_match ? S_RESP : S_UL_CHECK;
         S_B_READ:   state_in = S_B_EXEC;
         S_B_EXEC:   state_in = stat.boost_last ? S_RESP : S_B_READ;
         S_RESP:     state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = CMD_NONE;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) cmd = CMD_LOAD;
         end
         S_READ:     cmd = CMD_READ;
         S_EXEC:     cmd = CMD_EXEC;
         S_UL_CHECK: cmd = CMD_UL_CHECK;
         S_UL_NEXT:  cmd = CMD_UL_NEXT;
         S_B_READ:   cmd = CMD_B_READ;
         S_B_EXEC:   cmd = CMD_B_EXEC;
         S_RESP:     rsp_strobe = 1'b1;
         default:    cmd = CMD_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/mlfq_datapath.sv]
// Scheduler datapath: task table, link memory, queue pointers, counters and result word
module mlfq_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  mlfq_pkg::cmd_type                   cmd,
   input  mlfq_pkg::req_type                   req_word,
   input  logic                                csr_we,
   input  logic [mlfq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mlfq_pkg::CSR_DATA_W-1:0]     csr_data,
   output mlfq_pkg::stat_type                  stat,
   output mlfq_pkg::rsp_type                   rsp_word
);
   import mlfq_pkg::*;

   req_type             req_ff, req_in;
   rsp_type             rsp_ff, rsp_in;
   logic [TICK_W-1:0]   slice_ff [NUM_SLICES];
   logic [TICK_W-1:0]   slice_in [NUM_SLICES];
   logic [BOOST_W-1:0]  interval_ff, interval_in;
   logic [BOOST_W-1:0]  bcount_ff, bcount_in;
   logic [TASK_W-1:0]   head_ff [NUM_LEVELS];
   logic [TASK_W-1:0]   head_in [NUM_LEVELS];
   logic [TASK_W-1:0]   tail_ff [NUM_LEVELS];
   logic [TASK_W-1:0]   tail_in [NUM_LEVELS];
   logic [NUM_LEVELS-1:0] qempty_ff, qempty_in;
   logic [TASK_W-1:0]   run_id_ff, run_id_in;
   logic                run_valid_ff, run_valid_in;
   logic [NUM_TASKS-1:0] valid_ff, valid_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [TASK_W-1:0]   cur_ff, cur_in;
   logic [TASK_W-1:0]   prev_ff, prev_in;
   logic                prev_none_ff, prev_none_in;
   logic [LEVEL_W-1:0]  lvl_ff, lvl_in;
   logic [TASK_W-1:0]   idx_ff, idx_in;

   logic                rec_we;
   logic [TASK_W-1:0]   rec_waddr;
   rec_type             rec_wdata;
   logic [TASK_W-1:0]   rec_raddr;
   logic [REC_W-1:0]    rec_rdata;
   logic                link_we;
   logic [TASK_W-1:0]   link_waddr;
   logic [TASK_W-1:0]   link_wdata;
   logic [TASK_W-1:0]   link_raddr;
   logic [TASK_W-1:0]   link_rdata;

   mlfq_ram #(.WIDTH(REC_W), .DEPTH(NUM_TASKS)) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr (rec_waddr),
      .wr_data (rec_wdata),
      .rd_addr (rec_raddr),
      .rd_data (rec_rdata)
   );

   mlfq_ram #(.WIDTH(TASK_W), .DEPTH(NUM_TASKS)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (link_raddr),
      .rd_data (link_rdata)
   );

   always_comb begin
      logic [LEVEL_W-1:0] fl;
      logic               any_ready;
      logic [TASK_W-1:0]  task_id;
      rec_type            rec;
      logic               push_en;
      logic [LEVEL_W-1:0] push_lvl;
      logic [TASK_W-1:0]  push_id;
      logic [LEVEL_W-1:0] nl;
      logic [TICK_W-1:0]  nt;
      logic [TICK_W-1:0]  slice;
      logic [BOOST_W-1:0] bsum;
      logic [TASK_W-1:0]  g;

      fl        = '0;
      any_ready = 1'b0;
      for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
         if (!qempty_ff[l]) begin
            fl        = LEVEL_W'(l);
            any_ready = 1'b1;
         end
      end
      task_id = TASK_W'(req_ff.task_req);
      rec     = rd_valid_ff ? rec_type'(rec_rdata) : '0;

      req_in       = req_ff;
      rsp_in       = rsp_ff;
      slice_in     = slice_ff;
      interval_in  = interval_ff;
      bcount_in    = bcount_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      qempty_in    = qempty_ff;
      run_id_in    = run_id_ff;
      run_valid_in = run_valid_ff;
      valid_in     = valid_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      prev_none_in = prev_none_ff;
      lvl_in       = lvl_ff;
      idx_in       = idx_ff;

      rec_we     = 1'b0;
      rec_waddr  = task_id;
      rec_wdata  = rec;
      rec_raddr  = idx_ff;
      link_we    = 1'b0;
      link_waddr = cur_ff;
      link_wdata = link_rdata;
      link_raddr = cur_ff;
      stat       = '0;
      push_en    = 1'b0;
      push_lvl   = '0;
      push_id    = task_id;
      nl         = rec.level;
      nt         = rec.ticks;
      slice      = slice_ff[NUM_SLICES-1];
      bsum       = bcount_ff;
      g          = head_ff[fl];

      unique case (cmd)
         CMD_LOAD: begin
            req_in = req_word;
            rsp_in = '0;
         end
         CMD_READ: begin
            link_raddr = head_ff[fl];
            priority if (req_ff.kind == KIND_CREATE || req_ff.kind == KIND_WAKE ||
                         req_ff.kind == KIND_BLOCK) begin
               rec_raddr = task_id;
            end else if (req_ff.kind == KIND_DISPATCH) begin
               rec_raddr = head_ff[fl];
            end else begin
               rec_raddr = run_id_ff;
            end
         end
         CMD_EXEC: begin
            unique case (req_ff.kind)
               KIND_TICK: begin
                  if (run_valid_ff && rec.ticks != '1) begin
                     rec_we          = 1'b1;
                     rec_waddr       = run_id_ff;
                     rec_wdata.ticks = TICK_W'(rec.ticks + 1'b1);
                  end
                  bsum      = (bcount_ff == '1) ? bcount_ff : BOOST_W'(bcount_ff + 1'b1);
                  bcount_in = bsum;
                  if (bsum >= interval_ff) begin
                     stat.need_boost = 1'b1;
                     qempty_in       = '1;
                     bcount_in       = '0;
                     rsp_in.boosted  = 1'b1;
                     idx_in          = '0;
                  end
               end
               KIND_CREATE: begin
                  if (rec.status == ST_UNUSED) begin
                     rec_we    = 1'b1;
                     rec_wdata = '{level: '0, ticks: '0, status: ST_READY};
                     push_en   = 1'b1;
                     push_lvl  = '0;
                  end
               end
               KIND_WAKE: begin
                  if (rec.status == ST_BLOCKED) begin
                     rec_we           = 1'b1;
                     rec_wdata.status = ST_READY;
                     push_en          = 1'b1;
                     push_lvl         = rec.level;
                  end
               end
               KIND_YIELD: begin
                  if (run_valid_ff) begin
                     if (int'(rec.level) < NUM_SLICES) begin
                        slice = slice_ff[2'(rec.level)];
                     end
                     if (rec.ticks >= slice) begin
                        if (int'(rec.level) != NUM_LEVELS - 1) begin
                           nl             = LEVEL_W'(rec.level + 1'b1);
                           rsp_in.demoted = 1'b1;
                        end
                        nt = '0;
                     end
                     rec_we       = 1'b1;
                     rec_waddr    = run_id_ff;
                     rec_wdata    = '{level: nl, ticks: nt, status: ST_READY};
                     push_en      = 1'b1;
                     push_lvl     = nl;
                     push_id      = run_id_ff;
                     run_valid_in = 1'b0;
                  end
               end
               KIND_BLOCK: begin
                  priority if (rec.status == ST_READY) begin
                     rec_we           = 1'b1;
                     rec_wdata.status = ST_BLOCKED;
                     lvl_in           = rec.level;
                     cur_in           = head_ff[rec.level];
                     prev_none_in     = 1'b1;
                     stat.need_unlink = 1'b1;
                  end else if (rec.status == ST_RUNNING) begin
                     rec_we           = 1'b1;
                     rec_wdata.status = ST_BLOCKED;
                     if (run_valid_ff && run_id_ff == task_id) run_valid_in = 1'b0;
                  end
               end
               KIND_DISPATCH: begin
                  if (!run_valid_ff && any_ready) begin
                     if (g == tail_ff[fl]) begin
                        qempty_in[fl] = 1'b1;
                     end else begin
                        head_in[fl] = link_rdata;
                     end
                     rec_we               = 1'b1;
                     rec_waddr            = g;
                     rec_wdata.status     = ST_RUNNING;
                     run_id_in            = g;
                     run_valid_in         = 1'b1;
                     rsp_in.dispatched    = 1'b1;
                     rsp_in.granted_task  = 6'(g);
                     rsp_in.granted_level = 2'(fl);
                  end
               end
               default: begin
               end
            endcase
         end
         CMD_UL_CHECK: begin
            link_raddr   = cur_ff;
            stat.ul_more = !qempty_ff[lvl_ff] && cur_ff != tail_ff[lvl_ff];
            if (!qempty_ff[lvl_ff] && cur_ff == tail_ff[lvl_ff] && cur_ff == task_id) begin
               if (prev_none_ff) begin
                  qempty_in[lvl_ff] = 1'b1;
               end else begin
                  tail_in[lvl_ff] = prev_ff;
               end
            end
         end
         CMD_UL_NEXT: begin
            stat.ul_match = (cur_ff == task_id);
            if (cur_ff == task_id) begin
               if (prev_none_ff) begin
                  head_in[lvl_ff] = link_rdata;
               end else begin
                  link_we    = 1'b1;
                  link_waddr = prev_ff;
                  link_wdata = link_rdata;
               end
            end else begin
               prev_in      = cur_ff;
               prev_none_in = 1'b0;
               cur_in       = link_rdata;
            end
         end
         CMD_B_READ: begin
            rec_raddr = idx_ff;
         end
         CMD_B_EXEC: begin
            stat.boost_last = (int'(idx_ff) == NUM_TASKS - 1);
            if (rec.status == ST_READY || rec.status == ST_RUNNING) begin
               rec_we    = 1'b1;
               rec_waddr = idx_ff;
               rec_wdata = '{level: '0, ticks: '0, status: rec.status};
               if (rec.status == ST_READY) begin
                  push_en  = 1'b1;
                  push_lvl = '0;
                  push_id  = idx_ff;
               end
            end
            idx_in = TASK_W'(idx_ff + 1'b1);
         end
         CMD_NONE: begin
         end
         default: begin
         end
      endcase

      if (push_en) begin
         if (qempty_ff[push_lvl]) begin
            head_in[push_lvl] = push_id;
         end else begin
            link_we    = 1'b1;
            link_waddr = tail_ff[push_lvl];
            link_wdata = push_id;
         end
         tail_in[push_lvl]   = push_id;
         qempty_in[push_lvl] = 1'b0;
      end

      if (rec_we) valid_in[rec_waddr] = 1'b1;
      rd_valid_in = valid_ff[rec_raddr];

      if (csr_we) begin
         unique case (csr_index)
            CSR_SLICE0: slice_in[0] = csr_data[TICK_W-1:0];
            CSR_SLICE1: slice_in[1] = csr_data[TICK_W-1:0];
            CSR_SLICE2: slice_in[2] = csr_data[TICK_W-1:0];
            CSR_SLICE3: slice_in[3] = csr_data[TICK_W-1:0];
            CSR_BOOST:  interval_in = csr_data[BOOST_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slice_ff     <= SLICE_RESET;
         interval_ff  <= BOOST_RESET;
         bcount_ff    <= '0;
         qempty_ff    <= '1;
         run_valid_ff <= 1'b0;
         valid_ff     <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         slice_ff     <= slice_in;
         interval_ff  <= interval_in;
         bcount_ff    <= bcount_in;
         qempty_ff    <= qempty_in;
         run_valid_ff <= run_valid_in;
         valid_ff     <= valid_in;
         rd_valid_ff  <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      rsp_ff       <= rsp_in;
      head_ff      <= head_in;
      tail_ff      <= tail_in;
      run_id_ff    <= run_id_in;
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      prev_none_ff <= prev_none_in;
      lvl_ff       <= lvl_in;
      idx_ff       <= idx_in;
   end

   assign rsp_word = rsp_ff;

endmodule

[src/mlfq_task_scheduler_top.sv]
// Top level of the multilevel feedback queue task scheduler
//
//   channel  ports                          handshake
//   request  start, busy, req_word          taken when start is high and busy low
//   result   rsp_strobe, rsp_word           one word per event, strobed one cycle
//   config   csr_we, csr_index, csr_data    written whenever csr_we is high
//
// Most events step through idle, read, execute and respond; the strobe comes in the respond state.
// A block of a queued task adds a check and a next step per queue entry walked through the link memory.
// A tick that fires a boost adds a read and an execute step per task slot for the table walk.
// Reset clears the table through valid bits at once; no clearing pass follows.
// The result strobe cannot be stalled; busy stays high until the strobe cycle ends.
module mlfq_task_scheduler_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  mlfq_pkg::req_type               req_word,
   output logic                            rsp_strobe,
   output mlfq_pkg::rsp_type               rsp_word,
   input  logic                            csr_we,
   input  logic [mlfq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mlfq_pkg::CSR_DATA_W-1:0] csr_data
);
   import mlfq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   mlfq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   mlfq_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_word  (req_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .stat      (stat),
      .rsp_word  (rsp_word)
   );

endmodule

[src/mlfq_checker.sv]
// Port-level checks for the scheduler top level, attached by bind
`include "mlfq_task_scheduler_top_defines.svh"

module mlfq_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input mlfq_pkg::rsp_type rsp_word
);
   import mlfq_pkg::*;

   `MLFQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   `MLFQ_ASSERT_NEXT(a_strobe_single, rsp_strobe, !rsp_strobe)
   `MLFQ_ASSERT_IMPLY(a_strobe_in_busy, rsp_strobe, busy)
   `MLFQ_ASSERT_IMPLY(a_no_grant_zero, rsp_strobe && !rsp_word.dispatched, rsp_word.granted_task == 6'd0 && rsp_word.granted_level == 2'd0)
   `MLFQ_ASSERT_IMPLY(a_grant_boost_excl, rsp_strobe, !(rsp_word.dispatched && rsp_word.boosted))

endmodule

bind mlfq_task_scheduler_top mlfq_checker u_mlfq_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_word   (rsp_word)
);
